// ----- hw/rtl/lmcs_pkg.sv -----
// Shared types and constants for the LED mode color sequencer.
package lmcs_pkg;

   localparam logic [1:0] CSR_BLINK_PERIOD = 2'd0;
   localparam logic [1:0] CSR_SATURATION   = 2'd1;
   localparam logic [1:0] CSR_VALUE        = 2'd2;

   localparam logic [7:0] BLINK_PERIOD_RST = 8'd8;
   localparam logic [7:0] SATURATION_RST   = 8'd255;
   localparam logic [7:0] VALUE_RST        = 8'd150;

   localparam logic [1:0] AUTO_MODE   = 2'd0;
   localparam logic [1:0] MANUAL_MODE = 2'd1;

   localparam logic [1:0] SUB_SEMI_AUTO = 2'd0;
   localparam logic [1:0] SUB_SHOVEL    = 2'd1;

   localparam logic [7:0] HUE_SPAN  = 8'd43;
   localparam logic [7:0] HUE_SCALE = 8'd6;
   localparam logic [7:0] FULL      = 8'd255;

   typedef enum logic [2:0] {
      KIND_MAGENTA,
      KIND_RED,
      KIND_BLUE,
      KIND_GREEN,
      KIND_BLACK,
      KIND_RAINBOW
   } color_kind_type;

   typedef struct packed {
      logic accept;
      logic calc;
      logic mix;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/lmcs_ctrl.sv -----
// Sequencer state machine for the LED mode color sequencer.
module lmcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lmcs_pkg::dp_status_type status,
   output lmcs_pkg::ctrl_cmd_type  cmd
);
   import lmcs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CALC = 4'b0010,
      S_MIX  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!status.emit) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/lmcs_dp.sv -----
// Datapath: settings, effect state, HSV unit and result register.
module lmcs_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   req_controller_ready,
   input  logic                   req_update_active,
   input  logic                   req_effects_enabled,
   input  logic [1:0]             req_operation_mode,
   input  logic [1:0]             req_manual_submode,
   input  lmcs_pkg::ctrl_cmd_type  cmd,
   output lmcs_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_red,
   output logic [7:0]             rsp_green,
   output logic [7:0]             rsp_blue
);
   import lmcs_pkg::*;

   logic [7:0] period_ff, sat_ff, val_ff;
   logic [7:0] hue_ff, hue_in;
   logic [7:0] blink_ff, blink_in;
   logic       red_on_ff, red_on_in;
   logic       was_on_ff, was_on_in;
   logic       emit_ff, emit_in;
   color_kind_type kind_ff, kind_in;
   logic [7:0] hsv_hue_ff;

   logic [7:0] blink_inc;
   logic [2:0] region;
   logic [7:0] region_base;
   logic [7:0] frac;
   logic [2:0] region_ff;
   logic [15:0] sf_ff, sg_ff;
   logic [7:0] p_ff, q_ff, t_ff;
   logic [15:0] p_prod, q_prod, t_prod;

   logic       valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic [7:0] red_in, green_in, blue_in;

   assign blink_inc = blink_ff + 8'd1;

   // Decide the result and the next effect state at acceptance.
   always_comb begin
      hue_in    = hue_ff;
      blink_in  = blink_ff;
      red_on_in = red_on_ff;
      was_on_in = was_on_ff;
      emit_in   = 1'b0;
      kind_in   = KIND_BLACK;
      if (req_controller_ready) begin
         if (req_update_active) begin
            was_on_in = 1'b1;
            emit_in   = 1'b1;
            kind_in   = KIND_MAGENTA;
         end else if (req_effects_enabled) begin
            was_on_in = 1'b1;
            case (req_operation_mode)
               AUTO_MODE: begin
                  emit_in  = 1'b1;
                  blink_in = blink_inc;
                  if (blink_inc >= period_ff) begin
                     red_on_in = !red_on_ff;
                     blink_in  = 8'd0;
                  end
                  kind_in = red_on_in ? KIND_RED : KIND_BLUE;
               end
               MANUAL_MODE: begin
                  emit_in = 1'b1;
                  case (req_manual_submode)
                     SUB_SEMI_AUTO: kind_in = KIND_GREEN;
                     SUB_SHOVEL:    kind_in = KIND_BLACK;
                     default: begin
                        kind_in = KIND_RAINBOW;
                        hue_in  = hue_ff + 8'd1;
                     end
                  endcase
               end
               default: begin
                  emit_in = 1'b0;
               end
            endcase
         end else if (was_on_ff) begin
            was_on_in = 1'b0;
            emit_in   = 1'b1;
            kind_in   = KIND_BLUE;
         end
      end
   end

   // Hue region by compare against region boundaries.
   always_comb begin
      if (hsv_hue_ff >= 8'd215) begin
         region = 3'd5;
      end else if (hsv_hue_ff >= 8'd172) begin
         region = 3'd4;
      end else if (hsv_hue_ff >= 8'd129) begin
         region = 3'd3;
      end else if (hsv_hue_ff >= 8'd86) begin
         region = 3'd2;
      end else if (hsv_hue_ff >= HUE_SPAN) begin
         region = 3'd1;
      end else begin
         region = 3'd0;
      end
      region_base = 8'(16'(region) * 16'(HUE_SPAN));
      frac        = 8'(16'(hsv_hue_ff - region_base) * 16'(HUE_SCALE));
   end

   assign p_prod = 16'(val_ff) * 16'(FULL - sat_ff);
   assign q_prod = 16'(val_ff) * 16'(FULL - sf_ff[15:8]);
   assign t_prod = 16'(val_ff) * 16'(FULL - sg_ff[15:8]);

   always_comb begin
      red_in   = 8'd0;
      green_in = 8'd0;
      blue_in  = 8'd0;
      case (kind_ff)
         KIND_MAGENTA: begin
            red_in  = FULL;
            blue_in = FULL;
         end
         KIND_RED:   red_in   = FULL;
         KIND_BLUE:  blue_in  = FULL;
         KIND_GREEN: green_in = FULL;
         KIND_RAINBOW: begin
            case (region_ff)
               3'd0: begin red_in = val_ff; green_in = t_ff;   blue_in = p_ff;   end
               3'd1: begin red_in = q_ff;   green_in = val_ff; blue_in = p_ff;   end
               3'd2: begin red_in = p_ff;   green_in = val_ff; blue_in = t_ff;   end
               3'd3: begin red_in = p_ff;   green_in = q_ff;   blue_in = val_ff; end
               3'd4: begin red_in = t_ff;   green_in = p_ff;   blue_in = val_ff; end
               default: begin red_in = val_ff; green_in = p_ff; blue_in = q_ff; end
            endcase
         end
         default: begin
            red_in = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= BLINK_PERIOD_RST;
         sat_ff    <= SATURATION_RST;
         val_ff    <= VALUE_RST;
         hue_ff    <= 8'd0;
         blink_ff  <= 8'd0;
         red_on_ff <= 1'b1;
         was_on_ff <= 1'b1;
         emit_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BLINK_PERIOD: period_ff <= csr_wdata;
               CSR_SATURATION:   sat_ff    <= csr_wdata;
               CSR_VALUE:        val_ff    <= csr_wdata;
               default: begin
                  period_ff <= period_ff;
               end
            endcase
         end
         if (cmd.accept) begin
            hue_ff    <= hue_in;
            blink_ff  <= blink_in;
            red_on_ff <= red_on_in;
            was_on_ff <= was_on_in;
            emit_ff   <= emit_in;
         end
         if (cmd.load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= kind_in;
         hsv_hue_ff <= hue_ff;
      end
      if (cmd.calc) begin
         region_ff <= region;
         sf_ff     <= 16'(sat_ff) * 16'(frac);
         sg_ff     <= 16'(sat_ff) * 16'(FULL - frac);
         p_ff      <= p_prod[15:8];
      end
      if (cmd.mix) begin
         q_ff <= q_prod[15:8];
         t_ff <= t_prod[15:8];
      end
      if (cmd.load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign status.emit     = emit_ff;
   assign status.out_free = !valid_ff || rsp_ready;

   assign rsp_valid = valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

// ----- hw/rtl/led_mode_color_sequencer.sv -----
// Top level of the LED mode color sequencer.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | flags, operation mode, manual submode
//   rsp     | out       | rsp_valid/rsp_ready   | red, green, blue
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// A request passes through accept, two HSV multiply steps and load of the result register.
// The two-step multiply path of the HSV unit sets those steps; one request is in work at a time.
// Reset restores the settings to 8/255/150, hue and blink count to zero, both flags to one.
// A full, untaken result register holds the last step until rsp_ready frees it.
// Requests that give no result return to idle from the emit step without waiting on rsp_ready.
module led_mode_color_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_controller_ready,
   input  logic       req_update_active,
   input  logic       req_effects_enabled,
   input  logic [1:0] req_operation_mode,
   input  logic [1:0] req_manual_submode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import lmcs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lmcs_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_controller_ready (req_controller_ready),
      .req_update_active    (req_update_active),
      .req_effects_enabled  (req_effects_enabled),
      .req_operation_mode   (req_operation_mode),
      .req_manual_submode   (req_manual_submode),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_red              (rsp_red),
      .rsp_green            (rsp_green),
      .rsp_blue             (rsp_blue)
   );

endmodule

// ----- hw/rtl/lmcs_check.sv -----
// Port checker for the LED mode color sequencer and its bind.
module lmcs_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("request accepted while busy");

   a_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result loaded outside the emit step");

endmodule

bind led_mode_color_sequencer lmcs_check u_lmcs_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);
